>>> rtl/hsl2rgb_pkg.sv
// ============================================================================
// hsl2rgb_pkg: shared constants and types for the HSL to RGB converter
// Fixed-point constants for the hue sector math, the lightness term and the
// final scale-and-divide, plus the stage enable group handed to each channel.
// ============================================================================
package hsl2rgb_pkg;

    // Full scale of saturation and lightness (100 percent in 1/16 units)
    localparam logic [10:0] PCT_FULL   = 11'd1600;
    // Twice the full scale, used for 1 - |2l - 1|
    localparam logic [11:0] PCT_TWICE  = 12'd3200;
    // One 60-degree sector in 1/64 degree units
    localparam logic [11:0] SECTOR_Q6  = 12'd3840;
    // Highest sector a 15-bit hue reaches; sectors 6 and up are grey
    localparam int unsigned SECTOR_MAX = 8;

    // Lightness weight: 1600 * 7680 over the common denominator
    localparam logic [23:0] LTERM_K    = 24'd12288000;

    // Common denominator is 3 * 5^5 * 2^21: shift out the power of two first
    localparam int unsigned POW_SHIFT  = 21;
    localparam logic [63:0] DIV_REM    = 64'd9375;
    // Reciprocal of the odd remainder, exact for 22-bit dividends
    localparam int unsigned RECIP_SHIFT = 36;
    localparam logic [22:0] RECIP_M    =
        23'(((64'd1 << RECIP_SHIFT) + DIV_REM - 64'd1) / DIV_REM);

    // Load enables of the per-channel pipeline stages
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

endpackage

>>> rtl/hsl2rgb_chan.sv
// ============================================================================
// hsl2rgb_chan: one color channel of the HSL to RGB pipeline
// Forms the channel numerator from the chroma product and its gain, adds the
// lightness term, scales by 255 and divides down to an 8-bit value.
// ============================================================================
module hsl2rgb_chan (
    input  logic                      clk,
    input  hsl2rgb_pkg::stage_en_t    en,
    input  logic [21:0]               chroma,    // s * (1 - |2l - 1|), stage 2
    input  logic signed [12:0]        gain,      // component weight, stage 2
    input  logic [34:0]               lterm,     // lightness term, stage 3
    output logic [7:0]                pix        // channel value, stage 6
);

    logic signed [35:0] prod_reg;
    logic signed [35:0] prod_next;
    logic [34:0]        num_reg;
    logic [34:0]        num_next;
    logic [21:0]        quot_reg;
    logic [21:0]        quot_next;
    logic [7:0]         pix_reg;
    logic [7:0]         pix_next;

    logic signed [35:0] sum;
    logic [42:0]        scaled;
    logic [44:0]        recip_prod;

    // Stage 3: weight the chroma product by the component gain
    assign prod_next = 36'($signed({1'b0, chroma})) * 36'(gain);

    // Stage 4: add the lightness term; the sum never goes negative
    assign sum      = $signed({1'b0, lterm}) + prod_reg;
    assign num_next = sum[34:0];

    // Stage 5: scale by 255 and drop the power-of-two part of the divisor
    assign scaled    = {num_reg, 8'b0} - 43'(num_reg);
    assign quot_next = scaled[42:hsl2rgb_pkg::POW_SHIFT];

    // Stage 6: divide by the odd remainder through its reciprocal
    assign recip_prod = 45'(quot_reg) * 45'(hsl2rgb_pkg::RECIP_M);
    assign pix_next   =
        recip_prod[hsl2rgb_pkg::RECIP_SHIFT + 7:hsl2rgb_pkg::RECIP_SHIFT];

    // Hold each stage unless its enable advances it
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            prod_reg <= prod_next;
        end
        if (en.s4)
        begin
            num_reg <= num_next;
        end
        if (en.s5)
        begin
            quot_reg <= quot_next;
        end
        if (en.s6)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

>>> rtl/hsl_to_rgb_converter_top.sv
// ============================================================================
// hsl_to_rgb_converter_top: HSL triple to 8-bit RGB pixel
// Six-stage pipeline: clamp and sector, chroma product and gains, component
// products, numerator sum, scale by 255, reciprocal divide.
//
// Channel   Direction  Payload (lowest bit first)
// s_*       in         hue_q6[14:0], saturation_q4[25:15], lightness_q4[36:26]
// m_*       out        red[7:0], green[15:8], blue[23:16]
//
// One transaction per clock cycle in steady state while m_tready does not stall
// the output; an accepted input passes through every stage on its way to m_tdata.
// Each stage carries a valid bit and loads whenever it is empty or the stage
// behind it moves, so bubbles close up and a stalled output holds its data
// while earlier stages keep filling.
// rst_n clears only the valid bits; payload registers are not reset.
// ============================================================================
module hsl_to_rgb_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // hue_q6, saturation_q4, lightness_q4, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red, green, blue
);

    typedef enum logic [1:0] {
        ROLE_ZERO,
        ROLE_CHROMA,
        ROLE_INTER
    } role_t;

    localparam int unsigned NSTAGE = 6;
    localparam logic signed [12:0] GAIN_CHROMA = 13'sd3840;
    localparam logic signed [12:0] GAIN_ZERO   = -13'sd3840;

    // Pipeline control
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] rdy;
    hsl2rgb_pkg::stage_en_t en;

    // Input fields
    logic [14:0] hue_in;
    logic [10:0] sat_in;
    logic [10:0] light_in;

    // Stage 1 registers
    logic [14:0] hue_s1_reg;
    logic [10:0] sat_s1_reg;
    logic [10:0] sat_s1_next;
    logic [10:0] light_s1_reg;
    logic [10:0] light_s1_next;
    logic [10:0] span_s1_reg;
    logic [10:0] span_s1_next;
    logic [3:0]  sector_s1_reg;
    logic [3:0]  sector_s1_next;

    // Stage 2 registers
    logic [21:0]        chroma_s2_reg;
    logic [21:0]        chroma_s2_next;
    logic [10:0]        light_s2_reg;
    logic signed [12:0] gain_r_s2_reg;
    logic signed [12:0] gain_g_s2_reg;
    logic signed [12:0] gain_b_s2_reg;
    logic signed [12:0] gain_r_s2_next;
    logic signed [12:0] gain_g_s2_next;
    logic signed [12:0] gain_b_s2_next;

    // Stage 3 register
    logic [34:0] lterm_s3_reg;
    logic [34:0] lterm_s3_next;

    // Stage 1 and 2 helpers
    logic [11:0]        light_dbl;
    logic [11:0]        span_full;
    logic [14:0]        sector_base;
    logic [14:0]        hue_rem;
    logic signed [13:0] rem_dbl;
    logic signed [13:0] inter_gain;
    role_t              role_r;
    role_t              role_g;
    role_t              role_b;

    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    function automatic logic signed [12:0] gain_of(input role_t role,
                                                   input logic signed [13:0] inter);
        logic signed [12:0] g;
        case (role)
            ROLE_CHROMA: g = GAIN_CHROMA;
            ROLE_INTER:  g = inter[12:0];
            default:     g = GAIN_ZERO;
        endcase
        return g;
    endfunction

    // Unpack the input transaction
    assign hue_in   = s_tdata[14:0];
    assign sat_in   = s_tdata[25:15];
    assign light_in = s_tdata[36:26];

    // Ready ripples back from the output; a stage loads when empty or draining
    always_comb
    begin
        rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (rdy[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    assign en.s3 = rdy[2];
    assign en.s4 = rdy[3];
    assign en.s5 = rdy[4];
    assign en.s6 = rdy[5];

    // Stage 1: clamp inputs, form 1 - |2l - 1| and find the hue sector
    always_comb
    begin
        sat_s1_next   = (sat_in > hsl2rgb_pkg::PCT_FULL) ? hsl2rgb_pkg::PCT_FULL : sat_in;
        light_s1_next = (light_in > hsl2rgb_pkg::PCT_FULL) ? hsl2rgb_pkg::PCT_FULL
                                                           : light_in;
        light_dbl     = {light_s1_next, 1'b0};
        span_full     = (light_dbl >= 12'(hsl2rgb_pkg::PCT_FULL))
                        ? (hsl2rgb_pkg::PCT_TWICE - light_dbl) : light_dbl;
        span_s1_next  = span_full[10:0];
        sector_s1_next = 4'd0;
        for (int k = 1; k <= hsl2rgb_pkg::SECTOR_MAX; k++)
        begin
            if (hue_in >= 15'(k * hsl2rgb_pkg::SECTOR_Q6))
            begin
                sector_s1_next = 4'(k);
            end
        end
    end

    // Stage 2: chroma product and per-channel gains from the sector
    always_comb
    begin
        chroma_s2_next = 22'(sat_s1_reg) * 22'(span_s1_reg);
        sector_base    = 15'(sector_s1_reg) * 15'(hsl2rgb_pkg::SECTOR_Q6);
        hue_rem        = hue_s1_reg - sector_base;
        rem_dbl        = $signed({1'b0, hue_rem[11:0], 1'b0});
        inter_gain     = sector_s1_reg[0] ? (14'sd3840 - rem_dbl) : (rem_dbl - 14'sd3840);
        role_r = ROLE_ZERO;
        role_g = ROLE_ZERO;
        role_b = ROLE_ZERO;
        case (sector_s1_reg)
            4'd0:
            begin
                role_r = ROLE_CHROMA;
                role_g = ROLE_INTER;
            end
            4'd1:
            begin
                role_r = ROLE_INTER;
                role_g = ROLE_CHROMA;
            end
            4'd2:
            begin
                role_g = ROLE_CHROMA;
                role_b = ROLE_INTER;
            end
            4'd3:
            begin
                role_g = ROLE_INTER;
                role_b = ROLE_CHROMA;
            end
            4'd4:
            begin
                role_r = ROLE_INTER;
                role_b = ROLE_CHROMA;
            end
            4'd5:
            begin
                role_r = ROLE_CHROMA;
                role_b = ROLE_INTER;
            end
            default:
            begin
                role_r = ROLE_ZERO;
            end
        endcase
        gain_r_s2_next = gain_of(role_r, inter_gain);
        gain_g_s2_next = gain_of(role_g, inter_gain);
        gain_b_s2_next = gain_of(role_b, inter_gain);
    end

    // Stage 3: lightness term over the common denominator
    assign lterm_s3_next = 35'(light_s2_reg) * 35'(hsl2rgb_pkg::LTERM_K);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold or advance the front stages
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            hue_s1_reg    <= hue_in;
            sat_s1_reg    <= sat_s1_next;
            light_s1_reg  <= light_s1_next;
            span_s1_reg   <= span_s1_next;
            sector_s1_reg <= sector_s1_next;
        end
        if (rdy[1])
        begin
            chroma_s2_reg <= chroma_s2_next;
            light_s2_reg  <= light_s1_reg;
            gain_r_s2_reg <= gain_r_s2_next;
            gain_g_s2_reg <= gain_g_s2_next;
            gain_b_s2_reg <= gain_b_s2_next;
        end
        if (en.s3)
        begin
            lterm_s3_reg <= lterm_s3_next;
        end
    end

    hsl2rgb_chan u_chan_r (
        .clk    (clk),
        .en     (en),
        .chroma (chroma_s2_reg),
        .gain   (gain_r_s2_reg),
        .lterm  (lterm_s3_reg),
        .pix    (red)
    );

    hsl2rgb_chan u_chan_g (
        .clk    (clk),
        .en     (en),
        .chroma (chroma_s2_reg),
        .gain   (gain_g_s2_reg),
        .lterm  (lterm_s3_reg),
        .pix    (green)
    );

    hsl2rgb_chan u_chan_b (
        .clk    (clk),
        .en     (en),
        .chroma (chroma_s2_reg),
        .gain   (gain_b_s2_reg),
        .lterm  (lterm_s3_reg),
        .pix    (blue)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = {blue, green, red};

endmodule

>>> test/tb_hsl_to_rgb_converter_top.sv
// ============================================================================
// tb_hsl_to_rgb_converter_top: self-checking bench for the HSL to RGB pipeline
// Streams hue/saturation/lightness triples into the converter with random
// gaps and output stalls. Each accepted triple is converted to its exact
// RGB pixel with integer math over a common denominator. The expected pixels
// are queued and compared channel by channel against every output transaction.
// ============================================================================
module tb_hsl_to_rgb_converter_top;

    // Full scale of saturation and lightness, one hue sector, and the
    // common denominator 2 * 1600 * 1600 * 3840 of all intermediates
    localparam logic [63:0] FULL_SCALE  = 64'd1600;
    localparam logic [63:0] SECTOR_SPAN = 64'd3840;
    localparam logic [63:0] DENOMINATOR = 64'd19660800000;
    localparam int          RANDOM_HSL  = 750;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          FLUSH_WAIT  = 24;

    typedef struct packed {
        logic [10:0] lightness_q4;
        logic [10:0] saturation_q4;
        logic [14:0] hue_q6;
    } hsl_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct {
        hsl_t hsl;
        bit   drain_first;
    } hsl_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // hue_q6, saturation_q4, lightness_q4, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // red, green, blue

    hsl_item_t hsl_q[$];
    pixel_t    pixel_q[$];
    hsl_t      sent_hsl;
    pixel_t    got_pixel;
    pixel_t    want_pixel;
    int        send_wait;
    int        recv_wait;
    bit        send_calm;
    bit        recv_calm;
    int        fail_count;
    int        cycle_count;

    hsl_to_rgb_converter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Convert one triple to its pixel, exact until the final truncation
    function automatic pixel_t hsl_to_pixel(hsl_t px);
        logic [63:0] sat;
        logic [63:0] lum;
        logic [63:0] span;
        logic [63:0] hmod;
        logic [63:0] ramp;
        logic [63:0] chroma;
        logic [63:0] inter;
        logic [63:0] base;
        logic [63:0] rn;
        logic [63:0] gn;
        logic [63:0] bn;
        logic [63:0] sector;
        pixel_t      res;
        sat  = (64'(px.saturation_q4) > FULL_SCALE) ? FULL_SCALE : 64'(px.saturation_q4);
        lum  = (64'(px.lightness_q4) > FULL_SCALE) ? FULL_SCALE : 64'(px.lightness_q4);
        // span / 1600 is 1 - |2l - 1|
        span = (2 * lum >= FULL_SCALE) ? (4 * FULL_SCALE - 2 * lum) - FULL_SCALE * 2
                                        + FULL_SCALE * 0 : 2 * lum;
        if (2 * lum >= FULL_SCALE)
            span = 2 * FULL_SCALE - 2 * lum;
        // ramp / 3840 is 1 - |(h/60 mod 2) - 1|
        hmod   = 64'(px.hue_q6) % (2 * SECTOR_SPAN);
        ramp   = (hmod >= SECTOR_SPAN) ? (2 * SECTOR_SPAN - hmod) : hmod;
        chroma = sat * span * (2 * SECTOR_SPAN);
        inter  = sat * span * ramp * 2;
        base   = lum * FULL_SCALE * (2 * SECTOR_SPAN) - sat * span * SECTOR_SPAN;
        sector = 64'(px.hue_q6) / SECTOR_SPAN;
        rn = base;
        gn = base;
        bn = base;
        case (sector)
            64'd0:   begin rn += chroma; gn += inter;  end
            64'd1:   begin rn += inter;  gn += chroma; end
            64'd2:   begin gn += chroma; bn += inter;  end
            64'd3:   begin gn += inter;  bn += chroma; end
            64'd4:   begin rn += inter;  bn += chroma; end
            64'd5:   begin rn += chroma; bn += inter;  end
            default: begin end
        endcase
        res.red   = 8'((64'd255 * rn) / DENOMINATOR);
        res.green = 8'((64'd255 * gn) / DENOMINATOR);
        res.blue  = 8'((64'd255 * bn) / DENOMINATOR);
        return res;
    endfunction

    // Draw a percentage field: mostly in range, some extremes, some near half, some above full
    function automatic logic [10:0] rand_pct();
        case ($urandom_range(0, 9))
            0:       return 11'($urandom_range(0, 2047));
            1:       return $urandom_range(0, 1) ? 11'd1600 : 11'd0;
            2:       return 11'($urandom_range(790, 810));
            default: return 11'($urandom_range(0, 1600));
        endcase
    endfunction

    // Draw a hue: mostly colored sectors, some near sector edges, some grey
    function automatic logic [14:0] rand_hue();
        case ($urandom_range(0, 7))
            0:       return 15'($urandom_range(0, 32767));
            1:       return 15'($urandom_range(1, 8) * 3840 - $urandom_range(0, 1));
            default: return 15'($urandom_range(0, 23039));
        endcase
    endfunction

    function automatic void queue_hsl(int hue, int sat, int lum, bit drain_first);
        hsl_item_t it;
        it.hsl.hue_q6        = 15'(hue);
        it.hsl.saturation_q4 = 11'(sat);
        it.hsl.lightness_q4  = 11'(lum);
        it.drain_first       = drain_first;
        hsl_q.push_back(it);
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Driver: present queued triples, predict each one on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pixel_q.push_back(hsl_to_pixel(sent_hsl));
                if ($urandom_range(0, 31) == 0)
                    send_calm = !send_calm;
                send_wait = send_calm ? 0 : $urandom_range(0, 16);
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the transaction until taken
            end
            else if (send_wait > 0)
            begin
                send_wait--;
                s_tvalid <= 1'b0;
            end
            else if (hsl_q.size() != 0 && !(hsl_q[0].drain_first && pixel_q.size() != 0))
            begin
                sent_hsl = hsl_q[0].hsl;
                hsl_q.pop_front();
                s_tdata  <= {3'b000, sent_hsl};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: check each pixel against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_pixel = m_tdata;
                if (pixel_q.size() == 0)
                begin
                    $error("unexpected pixel %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want_pixel = pixel_q.pop_front();
                    if (got_pixel.red !== want_pixel.red)
                    begin
                        $error("red expected %0d actual %0d", want_pixel.red, got_pixel.red);
                        fail_count++;
                    end
                    if (got_pixel.green !== want_pixel.green)
                    begin
                        $error("green expected %0d actual %0d",
                               want_pixel.green, got_pixel.green);
                        fail_count++;
                    end
                    if (got_pixel.blue !== want_pixel.blue)
                    begin
                        $error("blue expected %0d actual %0d",
                               want_pixel.blue, got_pixel.blue);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 16);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus and end of test
    initial
    begin
        // Sector edges at full saturation, half lightness
        queue_hsl(0, 1600, 800, 0);
        queue_hsl(3839, 1600, 800, 0);
        queue_hsl(3840, 1600, 800, 0);
        queue_hsl(7679, 1600, 800, 0);
        queue_hsl(7680, 1600, 800, 0);
        queue_hsl(11520, 1600, 800, 0);
        queue_hsl(15360, 1600, 800, 0);
        queue_hsl(19200, 1600, 800, 0);
        queue_hsl(23039, 1600, 800, 0);
        // Hue at or past a full turn gives grey
        queue_hsl(23040, 1600, 800, 0);
        queue_hsl(32767, 1600, 600, 0);
        // Saturation and lightness extremes, including values above full
        queue_hsl(1920, 0, 0, 0);
        queue_hsl(1920, 1600, 0, 0);
        queue_hsl(1920, 1600, 1600, 0);
        queue_hsl(1920, 0, 1600, 0);
        queue_hsl(9000, 2047, 800, 0);
        queue_hsl(9000, 1600, 2047, 0);
        queue_hsl(32767, 2047, 2047, 0);
        queue_hsl(5000, 1600, 799, 0);
        queue_hsl(5000, 1600, 801, 0);
        queue_hsl(5000, 800, 400, 0);
        queue_hsl(17000, 1234, 1400, 0);
        // Random triples; drain the pipeline before two of them
        for (int i = 0; i < RANDOM_HSL; i++)
            queue_hsl(rand_hue(), rand_pct(), rand_pct(), i == 0 || i == RANDOM_HSL / 2);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (hsl_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (FLUSH_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> hsl_to_rgb_converter_top.f
rtl/hsl2rgb_pkg.sv
rtl/hsl2rgb_chan.sv
rtl/hsl_to_rgb_converter_top.sv
test/tb_hsl_to_rgb_converter_top.sv
